FILE: rtl/core/lmss_pkg.sv
// Shared types, constants and field layout for the LED matrix scroll scanner.
`default_nettype none

package lmss_pkg;

    localparam int STORE_GLYPHS_DEF = 64;
    localparam int GLYPH_LINES      = 8;
    localparam int READS_PER_FRAME  = 2 * GLYPH_LINES;

    localparam logic [15:0] PERIOD_RESET = 16'd500;
    localparam logic [5:0]  COUNT_RESET  = 6'd15;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic clear;
        logic load;
        logic tick;
        logic rd_issue;
        logic advance;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic due;
        logic rd_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/lmss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/lmss_ctrl.sv
// Controller state machine that sequences clearing, loads, ticks and frame rebuilds.
`default_nettype none

module lmss_ctrl import lmss_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire logic i_command,
    output logic      o_s_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept = i_s_tvalid & r_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && i_command == CMD_TICK) begin
                    n_state = i_sts.due ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                if (i_sts.rd_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.load     = w_accept & (i_command == CMD_LOAD);
        o_cmd.tick     = w_accept & (i_command == CMD_TICK);
        o_cmd.rd_issue = (r_state == S_READ);
        o_cmd.advance  = (r_state == S_FIN);
        o_cmd.emit     = (r_state == S_OUT) & i_sts.out_free;
    end

    assign o_s_tready = r_ready;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == S_IDLE)
        else $error("input ready outside the idle state");

    a_emit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE) && o_s_tready)
        else $error("controller did not return to idle after a result");

endmodule

`default_nettype wire

FILE: rtl/core/lmss_dp.sv
// Datapath with glyph store, frame registers, scroll counters and the result register.
`default_nettype none

module lmss_dp import lmss_pkg::*; #(
    parameter int STORE_GLYPHS = STORE_GLYPHS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_sts                        o_sts,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_m_tready,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tuser
);

    localparam int DEPTH = STORE_GLYPHS * GLYPH_LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW - 3;

    logic [15:0]    r_period;
    logic [5:0]     r_count;
    logic [15:0]    r_elapsed;
    logic [2:0]     r_shift;
    logic [5:0]     r_pos;
    logic [2:0]     r_scan;
    logic [7:0]     r_frame [GLYPH_LINES];
    logic [AW-1:0]  r_clr_addr;
    logic [3:0]     r_rd_k;
    logic           r_rd_vld;
    logic           r_rd_hi;
    logic [2:0]     r_rd_line;
    logic           r_rd_zero;
    logic [7:0]     r_lo;
    logic           r_scrolled;
    logic           r_m_valid;
    logic [2:0]     r_m_index;
    logic [7:0]     r_m_drive;
    logic [7:0]     r_m_row;
    logic           r_m_scrolled;

    logic [5:0]     w_ld_slot;
    logic [2:0]     w_ld_line;
    logic [7:0]     w_ld_bits;
    logic           w_ld_ok;
    logic [6:0]     w_rd_slot;
    logic           w_rd_ok;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic [7:0]     w_wr_data;
    logic [AW-1:0]  w_rd_addr;
    logic [7:0]     w_ram_q;
    logic [7:0]     w_line;
    logic [15:0]    w_pair;
    logic [16:0]    w_next;
    logic           w_due;

    assign w_ld_slot = i_s_tdata[5:0];
    assign w_ld_line = i_s_tdata[8:6];
    assign w_ld_bits = i_s_tdata[16:9];
    assign w_ld_ok   = 32'(w_ld_slot) < STORE_GLYPHS;

    assign w_rd_slot = {1'b0, r_pos} + {6'd0, r_rd_k[0]};
    assign w_rd_ok   = 32'(w_rd_slot) < STORE_GLYPHS;
    assign w_rd_addr = {SW'(w_rd_slot), r_rd_k[3:1]};

    assign w_wr_en   = i_cmd.clear | (i_cmd.load & w_ld_ok);
    assign w_wr_addr = i_cmd.clear ? r_clr_addr : {SW'(w_ld_slot), w_ld_line};
    assign w_wr_data = i_cmd.clear ? 8'd0 : w_ld_bits;

    lmss_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_q)
    );

    assign w_line = r_rd_zero ? 8'd0 : w_ram_q;
    assign w_pair = {w_line, r_lo} >> r_shift;
    assign w_next = {1'b0, r_elapsed} + 17'd1;
    assign w_due  = w_next >= {1'b0, r_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_count    <= COUNT_RESET;
            r_elapsed  <= '0;
            r_shift    <= '0;
            r_pos      <= '0;
            r_scan     <= '0;
            r_clr_addr <= '0;
            r_rd_k     <= '0;
            r_rd_vld   <= 1'b0;
            r_scrolled <= 1'b0;
            r_m_valid  <= 1'b0;
            for (int i = 0; i < GLYPH_LINES; i++) begin
                r_frame[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_COUNT:  r_count  <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.tick) begin
                r_elapsed  <= w_due ? 16'd0 : w_next[15:0];
                r_scrolled <= w_due;
            end
            if (i_cmd.rd_issue) begin
                r_rd_k <= r_rd_k + 4'd1;
            end
            r_rd_vld <= i_cmd.rd_issue;
            if (r_rd_vld && r_rd_hi) begin
                r_frame[r_rd_line] <= w_pair[7:0];
            end
            if (i_cmd.advance) begin
                r_shift <= r_shift + 3'd1;
                if (r_shift == 3'd7) begin
                    r_pos <= (r_pos == r_count) ? 6'd0 : r_pos + 6'd1;
                end
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
                r_scan    <= r_scan + 3'd1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_hi   <= r_rd_k[0];
            r_rd_line <= r_rd_k[3:1];
            r_rd_zero <= !w_rd_ok;
        end
        if (r_rd_vld && !r_rd_hi) begin
            r_lo <= w_line;
        end
        if (i_cmd.emit) begin
            r_m_index    <= r_scan;
            r_m_drive    <= ~(8'd1 << r_scan);
            r_m_row      <= r_frame[r_scan];
            r_m_scrolled <= r_scrolled;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.due      = w_due;
        o_sts.rd_last  = (r_rd_k == 4'(READS_PER_FRAME - 1));
        o_sts.out_free = !r_m_valid | i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'd0, r_m_row, r_m_drive, r_m_index};
    assign o_m_tuser  = r_m_scrolled;

    a_advance_after_last_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> r_rd_vld && r_rd_hi && (r_rd_line == 3'd7))
        else $error("scroll advanced before the last frame line was built");

    a_one_column_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> ($countones(r_m_drive) == 7) && (r_m_drive[r_m_index] == 1'b0))
        else $error("column select is not one-hot low at the driven column");

    a_scan_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_scan == $past(r_scan) + 3'd1)
        else $error("scan column did not step with the result");

endmodule

`default_nettype wire

FILE: rtl/core/led_matrix_scroll_scanner.sv
// A load beat is written in the cycle it is accepted and gives no result.
// A tick with no scroll step has its result registered once the output is free.
// A tick that rebuilds the frame first makes 16 glyph store reads on one port.
// A new beat is accepted while an earlier result still waits at the output.
// After reset all STORE_GLYPHS*8 glyph store lines (512 by default) are cleared
// with input ready low; configuration writes are taken at any time.
`default_nettype none

module led_matrix_scroll_scanner import lmss_pkg::*; #(
    parameter int STORE_GLYPHS = STORE_GLYPHS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // glyph_slot [5:0], glyph_line [8:6], line_bits [16:9], zeros above
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    // command
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // column_index [2:0], column_drive [10:3], row_drive [18:11], zeros above
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
    // scrolled
    output logic                       m_axis_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lmss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_command  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lmss_dp #(
        .STORE_GLYPHS (STORE_GLYPHS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the LED matrix scroll scanner: glyph loads, ticks and scrolling.
`timescale 1ns / 1ps

module testbench;
    import lmss_pkg::*;

    typedef struct {
        logic [2:0] column;
        logic [7:0] col_drive;
        logic [7:0] row_bits;
        logic       scrolled;
    } t_column_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Scanner state as predicted from the accepted beats.
    logic [7:0]  glyph_mem [0:STORE_GLYPHS_DEF*GLYPH_LINES-1];
    logic [7:0]  frame_lines [0:GLYPH_LINES-1];
    logic [2:0]  shift_q;
    logic [5:0]  pos_q;
    logic [16:0] elapsed_q;
    logic [2:0]  scan_q;
    logic [15:0] period_q;
    logic [5:0]  count_q;

    t_column_beat pending_columns [$];
    int unsigned  mismatch_count = 0;
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    logic         hold_active = 1'b0;
    event         start_hold;

    led_matrix_scroll_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // The receiver holds off for a long stretch whenever a test asks for it.
    initial forever begin
        @(start_hold);
        hold_active = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_active = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !hold_active && ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [7:0] store_line(input logic [6:0] slot, input logic [2:0] line);
        if (slot >= STORE_GLYPHS_DEF)
            return 8'h00;
        return glyph_mem[{slot[5:0], line}];
    endfunction

    task automatic advance_scanner(output t_column_beat beat);
        logic [15:0] wide;
        logic        rebuilt;
        rebuilt = 1'b0;
        elapsed_q = elapsed_q + 17'd1;
        if (elapsed_q >= {1'b0, period_q}) begin
            elapsed_q = '0;
            rebuilt = 1'b1;
            for (int i = 0; i < GLYPH_LINES; i++) begin
                wide = ({8'h00, store_line({1'b0, pos_q}, 3'(i))} >> shift_q)
                     | ({8'h00, store_line({1'b0, pos_q} + 7'd1, 3'(i))} << (4'd8 - shift_q));
                frame_lines[i] = wide[7:0];
            end
            shift_q = shift_q + 3'd1;
            if (shift_q == 3'd0)
                pos_q = (pos_q == count_q) ? 6'd0 : pos_q + 6'd1;
        end
        elapsed_q[16] = 1'b0;
        beat.column    = scan_q;
        beat.col_drive = ~(8'h01 << scan_q);
        beat.row_bits  = frame_lines[scan_q];
        beat.scrolled  = rebuilt;
        scan_q = scan_q + 3'd1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_column_beat want;
        t_column_beat fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_GLYPHS_DEF * GLYPH_LINES; i++)
                glyph_mem[i] = 8'h00;
            for (int i = 0; i < GLYPH_LINES; i++)
                frame_lines[i] = 8'h00;
            shift_q   = '0;
            pos_q     = '0;
            elapsed_q = '0;
            scan_q    = '0;
            period_q  = PERIOD_RESET;
            count_q   = COUNT_RESET;
            pending_columns.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_columns.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                end else begin
                    want = pending_columns.pop_front();
                    if (m_axis_tdata[2:0] != want.column)
                        report_mismatch("column_index", m_axis_tdata[2:0], want.column);
                    if (m_axis_tdata[10:3] != want.col_drive)
                        report_mismatch("column_drive", m_axis_tdata[10:3], want.col_drive);
                    if (m_axis_tdata[18:11] != want.row_bits)
                        report_mismatch("row_drive", m_axis_tdata[18:11], want.row_bits);
                    if (m_axis_tuser != want.scrolled)
                        report_mismatch("scrolled", m_axis_tuser, want.scrolled);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PERIOD)
                    period_q = i_cfg_data;
                else if (i_cfg_index == CFG_COUNT)
                    count_q = i_cfg_data[5:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_LOAD) begin
                    glyph_mem[{s_axis_tdata[5:0], s_axis_tdata[8:6]}] = s_axis_tdata[16:9];
                end else begin
                    advance_scanner(fresh);
                    pending_columns.push_back(fresh);
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic cmd, input logic [5:0] slot, input logic [2:0] line,
                             input logic [7:0] bits);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, bits, line, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, 6'($urandom), 3'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_columns.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] period, input logic [5:0] count);
        wait_drained();
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_COUNT, {10'b0, count});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_scan();
        repeat (3) send_tick();
    endtask

    task automatic test_scroll_basics();
        send_beat(CMD_LOAD, 6'd1, 3'd0, 8'h81);
        send_beat(CMD_LOAD, 6'd1, 3'd3, 8'hFF);
        send_beat(CMD_LOAD, 6'd1, 3'd7, 8'h01);
        send_beat(CMD_LOAD, 6'd2, 3'd0, 8'h80);
        send_beat(CMD_LOAD, 6'd0, 3'd7, 8'hFF);
        send_beat(CMD_LOAD, 6'd63, 3'd7, 8'hAA);
        set_config(16'd0, 6'd1);
        repeat (10) send_tick();
        set_config(16'hFFFF, 6'd62);
        repeat (3) send_tick();
    endtask

    task automatic test_period_lowered();
        set_config(16'd1000, 6'd15);
        repeat (20) send_tick();
        set_config(16'd8, 6'd15);
        repeat (4) send_tick();
    endtask

    task automatic test_zero_count();
        set_config(16'd1, 6'd0);
        repeat (20) send_tick();
    endtask

    task automatic test_position_past_count();
        send_beat(CMD_LOAD, 6'd4, 3'd2, 8'h3C);
        send_beat(CMD_LOAD, 6'd5, 3'd2, 8'hC3);
        send_beat(CMD_LOAD, 6'd6, 3'd5, 8'h7E);
        set_config(16'd1, 6'd63);
        while (pos_q < 6'd5) send_tick();
        set_config(16'd1, 6'd2);
        while (pos_q < 6'd8) send_tick();
    endtask

    task automatic test_backpressure();
        set_config(16'd2, 6'd5);
        -> start_hold;
        repeat (24) send_tick();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [15:0] period, input logic [5:0] count);
        set_config(period, count);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int n = 0; n < 120; n++) begin
            if ($urandom_range(99) < 35)
                send_beat(CMD_LOAD, 6'($urandom_range(count + 1)), 3'($urandom),
                          8'($urandom));
            else
                send_tick();
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_scan();
        test_scroll_basics();
        test_period_lowered();
        test_zero_count();
        test_position_past_count();
        test_backpressure();
        test_random_phase(0, 0, 16'($urandom_range(1, 3)), 6'd62);
        test_random_phase(58, 0, 16'd0, 6'($urandom_range(63)));
        test_random_phase(0, 58, 16'($urandom_range(2, 12)), 6'd63);
        test_random_phase(22, 22, 16'd1, 6'($urandom_range(1, 20)));
        wait_drained();
        if (mismatch_count == 0 && pending_columns.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
